### hw/rtl/ibfp_pkg.sv
// Shared types, constants and helpers for the IMU burst frame parser.
// No dependencies; imported by every module of the block.
`default_nettype none

package ibfp_pkg;

    // Default configuration handed down from the top level
    localparam int IBFP_CAL_FRAMES  = 64;
    localparam int IBFP_QUEUE_DEPTH = 2;

    // Burst layout
    localparam int FRAME_LEN = 23;
    localparam int POS_W     = 5;
    localparam int ACC_OFS   = 0;
    localparam int GYR_OFS   = 6;
    localparam int ST1_POS   = 14;
    localparam int MAG_OFS   = 15;
    localparam int MOTION_BYTES = 12;

    localparam logic [POS_W-1:0] POS_IDLE = POS_W'(FRAME_LEN);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_LEN - 1);

    // Status bits and the dead-sensor pattern
    localparam int          ST1_READY_BIT = 0;
    localparam int          ST2_OVF_BIT   = 3;
    localparam logic [7:0]  BYTE_ALL_ONES = 8'hFF;

    localparam logic signed [15:0] S16_MAX = 16'sh7FFF;
    localparam logic signed [15:0] S16_MIN = -16'sh8000;

    // One assembled frame, moved from the front part to the back part
    typedef struct packed {
        logic [15:0] accel_x;
        logic [15:0] accel_y;
        logic [15:0] accel_z;
        logic [15:0] gyro_x;
        logic [15:0] gyro_y;
        logic [15:0] gyro_z;
        logic [15:0] mag_x;
        logic [15:0] mag_y;
        logic [15:0] mag_z;
        logic        motion_valid;
        logic        mag_good;
        logic        calibrating;
        logic        restart;
        logic        last;
    } t_frame_rec;

    // One finished result
    typedef struct packed {
        logic [15:0] accel_x;
        logic [15:0] accel_y;
        logic [15:0] accel_z;
        logic [15:0] gyro_x;
        logic [15:0] gyro_y;
        logic [15:0] gyro_z;
        logic [15:0] mag_x;
        logic [15:0] mag_y;
        logic [15:0] mag_z;
        logic        motion_valid;
        logic        mag_good;
        logic        calibrating;
    } t_result;

    // Subtract two signed words, clamping to the signed 16-bit range
    function automatic logic [15:0] sat_sub16(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] diff;
        diff = {a[15], a} - {b[15], b};
        if (diff[16] != diff[15]) begin
            sat_sub16 = diff[16] ? S16_MIN : S16_MAX;
        end else begin
            sat_sub16 = diff[15:0];
        end
    endfunction

endpackage

`default_nettype wire

### hw/rtl/ibfp_front.sv
// Front part: byte position tracking, frame assembly and run bookkeeping.
// Depends on ibfp_pkg; pushes complete frames into ibfp_fifo.
`default_nettype none

module ibfp_front import ibfp_pkg::*; #(
    parameter int CAL_FRAMES = IBFP_CAL_FRAMES
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_frame_start,
    input  wire logic        i_start_calibration,
    input  wire logic        i_q_full,
    output logic             o_q_push,
    output t_frame_rec       o_q_rec
);

    localparam int CNT_W = $clog2(CAL_FRAMES + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CAL_FRAMES - 1);

    logic [7:0]       r_bytes [0:FRAME_LEN-2];
    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_run, n_run;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_pend, n_pend;

    logic             accept;
    logic [POS_W-1:0] pos_eff;
    logic             complete;
    logic             run_now;
    logic             pend_now;
    logic             last_frame;
    logic             motion;

    // Stall only the byte that would close a frame while the queue is full
    assign full   = i_q_full && (r_pos == POS_LAST);
    assign accept = push && !full;

    // Position, run and frame count bookkeeping
    always_comb begin
        n_pos      = r_pos;
        n_run      = r_run;
        n_cnt      = r_cnt;
        n_pend     = r_pend;
        pos_eff    = r_pos;
        complete   = 1'b0;
        run_now    = r_run;
        pend_now   = r_pend;
        last_frame = 1'b0;
        if (accept) begin
            if (i_frame_start) begin
                pos_eff = '0;
                if (i_start_calibration) begin
                    run_now  = 1'b1;
                    pend_now = 1'b1;
                    n_run    = 1'b1;
                    n_cnt    = '0;
                    n_pend   = 1'b1;
                end
            end
            if (pos_eff < POS_IDLE) begin
                n_pos = pos_eff + 1'b1;
                if (pos_eff == POS_LAST) begin
                    complete = 1'b1;
                    n_pend   = 1'b0;
                    if (run_now) begin
                        last_frame = (n_cnt == CNT_LAST);
                        n_cnt      = n_cnt + 1'b1;
                        if (last_frame) begin
                            n_run = 1'b0;
                        end
                    end
                end
            end else begin
                n_pos = pos_eff;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= POS_IDLE;
            r_run  <= 1'b0;
            r_cnt  <= '0;
            r_pend <= 1'b0;
        end else begin
            r_pos  <= n_pos;
            r_run  <= n_run;
            r_cnt  <= n_cnt;
            r_pend <= n_pend;
        end
    end

    // Hold every byte but the last, which is taken straight from the port
    always_ff @(posedge i_clk) begin
        if (accept && (pos_eff < POS_LAST)) begin
            r_bytes[pos_eff] <= i_data_byte;
        end
    end

    // Dead sensor reads all ones over the accel and gyro bytes
    always_comb begin
        motion = 1'b0;
        for (int k = 0; k < MOTION_BYTES; k++) begin
            if (r_bytes[k] != BYTE_ALL_ONES) begin
                motion = 1'b1;
            end
        end
    end

    // Assemble the record for the closing beat
    always_comb begin
        o_q_push             = complete;
        o_q_rec.accel_x      = {r_bytes[ACC_OFS],     r_bytes[ACC_OFS + 1]};
        o_q_rec.accel_y      = {r_bytes[ACC_OFS + 2], r_bytes[ACC_OFS + 3]};
        o_q_rec.accel_z      = {r_bytes[ACC_OFS + 4], r_bytes[ACC_OFS + 5]};
        o_q_rec.gyro_x       = {r_bytes[GYR_OFS],     r_bytes[GYR_OFS + 1]};
        o_q_rec.gyro_y       = {r_bytes[GYR_OFS + 2], r_bytes[GYR_OFS + 3]};
        o_q_rec.gyro_z       = {r_bytes[GYR_OFS + 4], r_bytes[GYR_OFS + 5]};
        o_q_rec.mag_x        = {r_bytes[MAG_OFS + 1], r_bytes[MAG_OFS]};
        o_q_rec.mag_y        = {r_bytes[MAG_OFS + 3], r_bytes[MAG_OFS + 2]};
        o_q_rec.mag_z        = {r_bytes[MAG_OFS + 5], r_bytes[MAG_OFS + 4]};
        o_q_rec.motion_valid = motion;
        o_q_rec.mag_good     = r_bytes[ST1_POS][ST1_READY_BIT] && !i_data_byte[ST2_OVF_BIT];
        o_q_rec.calibrating  = run_now;
        o_q_rec.restart      = pend_now;
        o_q_rec.last         = last_frame;
    end

    // Position never strays past the idle code
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_IDLE)
        else $error("byte position out of range");

endmodule

`default_nettype wire

### hw/rtl/ibfp_fifo.sv
// Short frame queue between the front and back parts.
// Depends on ibfp_pkg for the frame record type.
`default_nettype none

module ibfp_fifo import ibfp_pkg::*; #(
    parameter int DEPTH = IBFP_QUEUE_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  t_frame_rec      i_rec,
    output logic            o_full,
    input  wire logic       i_pop,
    output t_frame_rec      o_rec,
    output logic            o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_frame_rec       r_mem [0:DEPTH-1];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rec   = r_mem[r_rd];

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/ibfp_div.sv
// Signed divider by the calibration frame count, three axes at once.
// Depends on ibfp_pkg; used by ibfp_back to turn bias sums into bias words.
`default_nettype none

module ibfp_div import ibfp_pkg::*; #(
    parameter int CAL_FRAMES = IBFP_CAL_FRAMES,
    parameter int SUM_W      = 16 + $clog2(CAL_FRAMES)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [2:0][SUM_W-1:0] i_sum,
    output logic                       o_done,
    output logic [2:0][15:0]           o_quo
);

    // Rounded-up reciprocal of the frame count; exact for every magnitude below 2**SUM_W
    localparam int     LOG_D  = $clog2(CAL_FRAMES);
    localparam int     SHIFT  = SUM_W + LOG_D;
    localparam int     MUL_W  = SUM_W + 1;
    localparam int     PROD_W = SUM_W + MUL_W;
    localparam longint RECIP  = ((longint'(1) << SHIFT) / longint'(CAL_FRAMES)) + longint'(1);
    localparam logic [MUL_W-1:0] MULT = MUL_W'(RECIP);

    logic                      r_busy;
    logic                      r_done;
    logic [2:0]                r_neg;
    logic [2:0][SUM_W-1:0]     r_mag;
    logic [2:0][15:0]          r_quo;

    logic [2:0][PROD_W-1:0]    prod;
    logic [2:0][15:0]          q_mag;

    // Advance the two stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= i_start;
            r_done <= r_busy;
        end
    end

    // Split each sum into sign and magnitude
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            for (int a = 0; a < 3; a++) begin
                r_neg[a] <= i_sum[a][SUM_W-1];
                r_mag[a] <= i_sum[a][SUM_W-1] ? (~i_sum[a] + 1'b1) : i_sum[a];
            end
        end
    end

    // Scale the magnitude by the reciprocal and keep the integer part
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            prod[a]  = PROD_W'(r_mag[a]) * PROD_W'(MULT);
            q_mag[a] = prod[a][SHIFT +: 16];
        end
    end

    // Restore the sign; the quotient always fits the signed 16-bit range
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            for (int a = 0; a < 3; a++) begin
                r_quo[a] <= r_neg[a] ? (~q_mag[a] + 1'b1) : q_mag[a];
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

    // A new run must not land on a division in flight
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider restarted while busy");

endmodule

`default_nettype wire

### hw/rtl/ibfp_back.sv
// Back part: gyro bias removal, calibration sums and the result register.
// Depends on ibfp_pkg and instantiates ibfp_div.
`default_nettype none

module ibfp_back import ibfp_pkg::*; #(
    parameter int CAL_FRAMES = IBFP_CAL_FRAMES
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_q_empty,
    input  t_frame_rec i_q_rec,
    output logic       o_q_pop,
    output t_result    o_result,
    output logic       empty,
    input  wire logic  pop
);

    localparam int SUM_W = 16 + $clog2(CAL_FRAMES);

    typedef enum logic [1:0] {
        ST_RUN  = 2'b01,
        ST_BIAS = 2'b10
    } t_back_state;

    t_back_state             r_state;
    logic [2:0][15:0]        r_bias;
    logic [2:0][SUM_W-1:0]   r_sum;
    t_result                 r_out;
    logic                    r_out_valid;

    logic                    take;
    logic [2:0][15:0]        raw;
    logic [2:0][15:0]        bias_eff;
    logic [2:0][15:0]        gyro_out;
    logic [2:0][SUM_W-1:0]   sum_new;
    logic                    div_start;
    logic                    div_done;
    logic [2:0][15:0]        div_quo;
    t_result                 res;

    // Take a frame when the result slot frees and no bias load is pending
    assign take    = !i_q_empty && (r_state == ST_RUN) && (!r_out_valid || pop);
    assign o_q_pop = take;
    assign empty   = !r_out_valid;
    assign o_result = r_out;

    assign raw[0] = i_q_rec.gyro_x;
    assign raw[1] = i_q_rec.gyro_y;
    assign raw[2] = i_q_rec.gyro_z;

    // Remove bias and extend the running sums
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            bias_eff[a] = i_q_rec.restart ? '0 : r_bias[a];
            gyro_out[a] = sat_sub16(raw[a], bias_eff[a]);
            sum_new[a]  = (i_q_rec.restart ? '0 : r_sum[a])
                        + SUM_W'($signed(raw[a]));
        end
    end

    always_comb begin
        res.accel_x      = i_q_rec.accel_x;
        res.accel_y      = i_q_rec.accel_y;
        res.accel_z      = i_q_rec.accel_z;
        res.gyro_x       = gyro_out[0];
        res.gyro_y       = gyro_out[1];
        res.gyro_z       = gyro_out[2];
        res.mag_x        = i_q_rec.mag_x;
        res.mag_y        = i_q_rec.mag_y;
        res.mag_z        = i_q_rec.mag_z;
        res.motion_valid = i_q_rec.motion_valid;
        res.mag_good     = i_q_rec.mag_good;
        res.calibrating  = i_q_rec.calibrating;
    end

    assign div_start = take && i_q_rec.last;

    ibfp_div #(
        .CAL_FRAMES (CAL_FRAMES),
        .SUM_W      (SUM_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_sum   (sum_new),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // Sequence bias state and the result slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_bias      <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_RUN: begin
                    if (take) begin
                        if (i_q_rec.restart) begin
                            r_bias <= '0;
                            r_sum  <= '0;
                        end
                        if (i_q_rec.calibrating) begin
                            r_sum <= sum_new;
                        end
                        if (i_q_rec.last) begin
                            r_state <= ST_BIAS;
                        end
                    end
                end
                ST_BIAS: begin
                    if (div_done) begin
                        r_bias  <= div_quo;
                        r_state <= ST_RUN;
                    end
                end
                default: begin
                    r_state <= ST_RUN;
                end
            endcase
            if (take) begin
                r_out_valid <= 1'b1;
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= res;
        end
    end

    // A finished division only arrives while a bias load is pending
    a_done_in_bias: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_BIAS))
        else $error("divider done outside bias load");

    // The closing frame of a run holds off the queue until the bias lands
    a_last_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |=> (r_state == ST_BIAS) && !o_q_pop)
        else $error("queue read during bias load");

    // An untaken result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !pop) |=> (r_out_valid && $stable(r_out)))
        else $error("pending result lost or changed");

endmodule

`default_nettype wire

### hw/rtl/imu_burst_frame_parser.sv
// IMU burst frame parser with gyro bias removal: top level.
// Ties ibfp_front, ibfp_fifo and ibfp_back together; depends on ibfp_pkg.
//
// The block takes one byte of a 23-byte sensor burst per clock while full is
// low and gives one result per complete frame: three big-endian accel words,
// three gyro words with the stored bias removed (saturated), three
// little-endian mag words and three flags. A byte with frame_start opens a
// new frame at position 0; bytes outside an open frame are dropped. The
// accepting edge of the closing byte writes the frame queue; the frame then
// moves into the result register on the ports once the result slot is free
// and no bias load is pending. full rises only while the closing byte of a
// frame is due and the frame queue (QUEUE_DEPTH entries) is full, so bytes
// stream one per cycle while results are taken. The frame that ends a
// calibration run starts a divide by CAL_FRAMES (a multiply by its reciprocal);
// the following frame waits in the queue until the new bias is in place.
`default_nettype none

module imu_burst_frame_parser import ibfp_pkg::*; #(
    parameter int CAL_FRAMES  = IBFP_CAL_FRAMES,
    parameter int QUEUE_DEPTH = IBFP_QUEUE_DEPTH
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         push,
    output logic              full,
    input  wire logic [7:0]   i_data_byte,
    input  wire logic         i_frame_start,
    input  wire logic         i_start_calibration,
    output logic              empty,
    input  wire logic         pop,
    output logic signed [15:0] o_accel_x,
    output logic signed [15:0] o_accel_y,
    output logic signed [15:0] o_accel_z,
    output logic signed [15:0] o_gyro_x,
    output logic signed [15:0] o_gyro_y,
    output logic signed [15:0] o_gyro_z,
    output logic signed [15:0] o_mag_x,
    output logic signed [15:0] o_mag_y,
    output logic signed [15:0] o_mag_z,
    output logic              o_motion_valid,
    output logic              o_mag_good,
    output logic              o_calibrating
);

    logic       q_full;
    logic       q_push;
    t_frame_rec q_in;
    logic       q_pop;
    t_frame_rec q_out;
    logic       q_empty;
    t_result    result;

    ibfp_front #(
        .CAL_FRAMES (CAL_FRAMES)
    ) u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .push                (push),
        .full                (full),
        .i_data_byte         (i_data_byte),
        .i_frame_start       (i_frame_start),
        .i_start_calibration (i_start_calibration),
        .i_q_full            (q_full),
        .o_q_push            (q_push),
        .o_q_rec             (q_in)
    );

    ibfp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_rec   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_rec   (q_out),
        .o_empty (q_empty)
    );

    ibfp_back #(
        .CAL_FRAMES (CAL_FRAMES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_rec   (q_out),
        .o_q_pop   (q_pop),
        .o_result  (result),
        .empty     (empty),
        .pop       (pop)
    );

    // Unpack the result register onto the ports
    assign o_accel_x      = result.accel_x;
    assign o_accel_y      = result.accel_y;
    assign o_accel_z      = result.accel_z;
    assign o_gyro_x       = result.gyro_x;
    assign o_gyro_y       = result.gyro_y;
    assign o_gyro_z       = result.gyro_z;
    assign o_mag_x        = result.mag_x;
    assign o_mag_y        = result.mag_y;
    assign o_mag_z        = result.mag_z;
    assign o_motion_valid = result.motion_valid;
    assign o_mag_good     = result.mag_good;
    assign o_calibrating  = result.calibrating;

endmodule

`default_nettype wire
